[hw/rtl/cfte_pkg.sv]
`timescale 1ns / 1ps
package cfte_pkg;

  // FD payload ceiling; the padded length is clipped to this.
  localparam int MAX_FD_PAYLOAD = 64;

  // Longest header: size/net, description x2, extended id x4, FD status x2.
  localparam int HDR_BYTES = 9;
  localparam int HDR_IDX_W = $clog2(HDR_BYTES);
  localparam int HDR_CNT_W = $clog2(HDR_BYTES + 1);

  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 8;

  // Item kinds (slave tuser)
  localparam logic [1:0] OP_HEADER  = 2'd0;
  localparam logic [1:0] OP_PAYLOAD = 2'd1;
  localparam logic [1:0] OP_END     = 2'd2;

  // Result codes (master tuser)
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_REMOTE_FD = 2'd1;
  localparam logic [1:0] ERR_LENGTH    = 2'd2;
  localparam logic [1:0] ERR_ID_RANGE  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_DATA,
    ST_WAIT_END,
    ST_PAD
  } state_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [7:0]  forced_dlc;
    logic [7:0]  data_length;
    logic        baud_switch;
    logic        is_remote;
    logic        is_fd;
    logic        is_extended;
    logic [31:0] arb_id;
    logic [15:0] description_id;
    logic [3:0]  net_id;
  } item_t;

  typedef struct packed {
    logic hdr_load;
    logic err_load;
    logic hdr_emit;
    logic pay_emit;
    logic pad_emit;
  } cmd_t;

  typedef struct packed {
    logic hdr_err;
    logic hdr_final;
    logic len_zero;
    logic pad_zero;
    logic pay_final;
    logic pad_final;
    logic out_free;
  } stat_t;

  function automatic logic [6:0] fd_dlc_len(input logic [3:0] dlc);
    logic [6:0] r;
    unique case (dlc)
      4'd0:  r = 7'd0;
      4'd1:  r = 7'd1;
      4'd2:  r = 7'd2;
      4'd3:  r = 7'd3;
      4'd4:  r = 7'd4;
      4'd5:  r = 7'd5;
      4'd6:  r = 7'd6;
      4'd7:  r = 7'd7;
      4'd8:  r = 7'd8;
      4'd9:  r = 7'd12;
      4'd10: r = 7'd16;
      4'd11: r = 7'd20;
      4'd12: r = 7'd24;
      4'd13: r = 7'd32;
      4'd14: r = 7'd48;
      4'd15: r = 7'd64;
    endcase
    return r;
  endfunction

  // {valid, dlc}: smallest DLC whose length covers len
  function automatic logic [4:0] len_to_dlc(input logic [7:0] len, input logic fd);
    logic [4:0] r;
    r = 5'd0;
    if (len <= 8'd8) begin
      r = {1'b1, len[3:0]};
    end else if (fd && (len <= 8'(MAX_FD_PAYLOAD))) begin
      for (int d = 15; d >= 9; d--) begin
        if (len <= {1'b0, fd_dlc_len(4'(d))}) begin
          r = {1'b1, 4'(d)};
        end
      end
    end
    return r;
  endfunction

endpackage

[hw/rtl/can_frame_transmit_encoder_top.sv]
`timescale 1ns / 1ps
// CAN frame transmit encoder: turns header / payload / end items into the device byte stream.
// Input channel s_axis: tuser = item kind (header, payload byte, end of frame); tdata carries the
//   header fields and the payload byte. Items that arrive out of sequence are taken and dropped.
// Output channel m_axis: one frame byte per transaction, tlast on the final byte of a frame,
//   tuser = result code. A header that fails its checks gives a single zero byte with tlast set
//   and a nonzero code, and the block stays ready for the next header.
// Timing: every result is written into the output register, so the outputs are registered.
//   A good header is taken, then its 6 to 9 header bytes leave one per cycle while m_axis_tready
//   allows; the input is held off meanwhile. Payload items stream at one per cycle when the output
//   is free, each straight into the output register. An end item is taken, then the zero padding
//   (up to 64 bytes) leaves one per cycle while m_axis_tready allows, with the input held off. One
//   output byte per cycle is the ceiling, set by the single output register.
// Stall: when m_axis_tready is low the output register holds; s_axis_tready drops in states that
//   need the output register, so no transaction is lost.
// Reset (rst, synchronous): back to waiting for a header, counters cleared, output empty.
module can_frame_transmit_encoder_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [3:0] net_id, [19:4] description_id, [51:20] arb_id, [52] is_extended, [53] is_fd,
  // [54] is_remote, [55] baud_switch, [63:56] data_length, [71:64] forced_dlc,
  // [79:72] payload_byte
  input  logic [cfte_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] out_byte
  output logic [cfte_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,
  // [1:0] result code
  output logic [1:0]                     m_axis_tuser
);

  cfte_pkg::item_t item;
  cfte_pkg::cmd_t  cmd;
  cfte_pkg::stat_t stat;

  // field layout of item_t matches the tdata packing, lowest field at bit 0
  assign item = cfte_pkg::item_t'(s_axis_tdata);

  cfte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .opcode   (s_axis_tuser),
    .stat     (stat),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  cfte_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_err   (m_axis_tuser)
  );

`ifndef ASSERT_OFF
  a_err_result: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != cfte_pkg::ERR_NONE)) |->
      (m_axis_tlast && (m_axis_tdata == 8'd0)))
    else $error("error result not a single zero byte marked last");
`endif

endmodule

[hw/rtl/cfte_datapath.sv]
`timescale 1ns / 1ps
module cfte_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  cfte_pkg::item_t              item,
  input  cfte_pkg::cmd_t               cmd,
  output cfte_pkg::stat_t              stat,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [cfte_pkg::M_TDATA_W-1:0] out_byte,
  output logic                         out_last,
  output logic [1:0]                   out_err
);

  logic [7:0]                    hdr_bytes [cfte_pkg::HDR_BYTES];
  logic [cfte_pkg::HDR_CNT_W-1:0] hdr_count;
  logic [cfte_pkg::HDR_IDX_W-1:0] hdr_idx;
  logic [7:0]                    payload_left;
  logic [6:0]                    padding_left;

  // header evaluation, straight from the incoming item
  logic [4:0]                    dlc_res;
  logic [3:0]                    dlc;
  logic                          forced_bad;
  logic                          id_bad;
  logic [6:0]                    map_len;
  logic [6:0]                    padded;
  logic [6:0]                    pad;
  logic [1:0]                    err_c;
  logic [cfte_pkg::HDR_CNT_W-1:0] hn_c;
  logic [7:0]                    size_c;
  logic [7:0]                    hb_c [cfte_pkg::HDR_BYTES];
  logic [7:0]                    status_b;
  logic [7:0]                    fd_dlc_b;
  logic                          emit;

  always_comb begin
    dlc_res    = cfte_pkg::len_to_dlc(item.data_length, item.is_fd);
    forced_bad = (item.forced_dlc != 8'd0) &&
                 ((item.forced_dlc > 8'd15) || (item.forced_dlc[3:0] < dlc_res[3:0]));
    dlc        = (item.forced_dlc != 8'd0) ? item.forced_dlc[3:0] : dlc_res[3:0];
    id_bad     = item.is_extended ? (item.arb_id[31:29] != 3'd0)
                                  : (item.arb_id[31:11] != 21'd0);

    if (item.is_fd && item.is_remote) begin
      err_c = cfte_pkg::ERR_REMOTE_FD;
    end else if (!dlc_res[4] || forced_bad) begin
      err_c = cfte_pkg::ERR_LENGTH;
    end else if (id_bad) begin
      err_c = cfte_pkg::ERR_ID_RANGE;
    end else begin
      err_c = cfte_pkg::ERR_NONE;
    end

    map_len = cfte_pkg::fd_dlc_len(dlc);
    if (item.is_fd) begin
      padded = (map_len > 7'(cfte_pkg::MAX_FD_PAYLOAD)) ? 7'(cfte_pkg::MAX_FD_PAYLOAD) : map_len;
    end else begin
      padded = (dlc <= 4'd8) ? {3'd0, dlc} : 7'd8;
    end
    pad = padded - item.data_length[6:0];

    hn_c   = cfte_pkg::HDR_CNT_W'(3) + (item.is_extended ? cfte_pkg::HDR_CNT_W'(4)
                                                         : cfte_pkg::HDR_CNT_W'(2))
           + (item.is_fd ? cfte_pkg::HDR_CNT_W'(2) : cfte_pkg::HDR_CNT_W'(1));
    size_c = 8'(hn_c) + item.data_length + {1'b0, pad};

    status_b = {1'b0, item.is_remote, 2'b00, dlc};
    fd_dlc_b = {item.baud_switch, 3'b000, dlc};

    for (int i = 0; i < cfte_pkg::HDR_BYTES; i++) begin
      hb_c[i] = 8'd0;
    end
    hb_c[0] = {size_c[3:0], item.net_id};
    hb_c[1] = item.description_id[15:8];
    hb_c[2] = item.description_id[7:0];
    if (item.is_extended) begin
      hb_c[3] = item.arb_id[28:21];
      hb_c[4] = {item.arb_id[20:18], 3'b010, item.arb_id[17:16]};
      hb_c[5] = item.arb_id[15:8];
      hb_c[6] = item.arb_id[7:0];
      hb_c[7] = item.is_fd ? 8'h0F : status_b;
      hb_c[8] = fd_dlc_b;
    end else begin
      hb_c[3] = item.arb_id[10:3];
      hb_c[4] = {item.arb_id[2:0], 5'd0};
      hb_c[5] = item.is_fd ? 8'h0F : status_b;
      hb_c[6] = fd_dlc_b;
    end
  end

  assign stat.hdr_err   = (err_c != cfte_pkg::ERR_NONE);
  assign stat.hdr_final = (cfte_pkg::HDR_CNT_W'(hdr_idx) ==
                           (hdr_count - cfte_pkg::HDR_CNT_W'(1)));
  assign stat.len_zero  = (payload_left == 8'd0);
  assign stat.pad_zero  = (padding_left == 7'd0);
  assign stat.pay_final = (payload_left == 8'd1);
  assign stat.pad_final = (padding_left == 7'd1);
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.hdr_load) begin
      for (int i = 0; i < cfte_pkg::HDR_BYTES; i++) begin
        hdr_bytes[i] <= hb_c[i];
      end
      hdr_count <= hn_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_idx      <= '0;
      payload_left <= 8'd0;
      padding_left <= 7'd0;
    end else begin
      if (cmd.hdr_load) begin
        hdr_idx      <= '0;
        payload_left <= item.data_length;
        padding_left <= pad;
      end
      if (cmd.hdr_emit) begin
        hdr_idx <= hdr_idx + cfte_pkg::HDR_IDX_W'(1);
      end
      if (cmd.pay_emit) begin
        payload_left <= payload_left - 8'd1;
      end
      if (cmd.pad_emit) begin
        padding_left <= padding_left - 7'd1;
      end
    end
  end

  // output register
  assign emit = cmd.err_load || cmd.hdr_emit || cmd.pay_emit || cmd.pad_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_load) begin
      out_byte <= 8'd0;
      out_last <= 1'b1;
      out_err  <= err_c;
    end else if (cmd.hdr_emit) begin
      out_byte <= hdr_bytes[hdr_idx];
      out_last <= stat.hdr_final && stat.len_zero && stat.pad_zero;
      out_err  <= cfte_pkg::ERR_NONE;
    end else if (cmd.pay_emit) begin
      out_byte <= item.payload_byte;
      out_last <= stat.pay_final && stat.pad_zero;
      out_err  <= cfte_pkg::ERR_NONE;
    end else if (cmd.pad_emit) begin
      out_byte <= 8'd0;
      out_last <= stat.pad_final;
      out_err  <= cfte_pkg::ERR_NONE;
    end
  end

endmodule

[hw/rtl/cfte_ctrl.sv]
`timescale 1ns / 1ps
module cfte_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       opcode,
  input  cfte_pkg::stat_t  stat,
  output logic             in_ready,
  output cfte_pkg::cmd_t   cmd
);

  cfte_pkg::state_t state;
  cfte_pkg::state_t state_next;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfte_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign accept = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cfte_pkg::ST_IDLE: begin
        if (accept && (opcode == cfte_pkg::OP_HEADER) && !stat.hdr_err) begin
          state_next = cfte_pkg::ST_HDR;
        end
      end
      cfte_pkg::ST_HDR: begin
        if (stat.out_free && stat.hdr_final) begin
          if (!stat.len_zero) begin
            state_next = cfte_pkg::ST_DATA;
          end else if (!stat.pad_zero) begin
            state_next = cfte_pkg::ST_WAIT_END;
          end else begin
            state_next = cfte_pkg::ST_IDLE;
          end
        end
      end
      cfte_pkg::ST_DATA: begin
        if (accept && (opcode == cfte_pkg::OP_PAYLOAD) && stat.pay_final) begin
          state_next = stat.pad_zero ? cfte_pkg::ST_IDLE : cfte_pkg::ST_WAIT_END;
        end
      end
      cfte_pkg::ST_WAIT_END: begin
        if (accept && (opcode == cfte_pkg::OP_END)) begin
          state_next = cfte_pkg::ST_PAD;
        end
      end
      cfte_pkg::ST_PAD: begin
        if (stat.out_free && stat.pad_final) begin
          state_next = cfte_pkg::ST_IDLE;
        end
      end
      default: state_next = cfte_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      cfte_pkg::ST_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free && (opcode == cfte_pkg::OP_HEADER)) begin
          cmd.hdr_load = !stat.hdr_err;
          cmd.err_load = stat.hdr_err;
        end
      end
      cfte_pkg::ST_HDR: begin
        cmd.hdr_emit = stat.out_free;
      end
      cfte_pkg::ST_DATA: begin
        in_ready     = stat.out_free;
        cmd.pay_emit = in_valid && stat.out_free && (opcode == cfte_pkg::OP_PAYLOAD);
      end
      cfte_pkg::ST_WAIT_END: begin
        in_ready = 1'b1;
      end
      cfte_pkg::ST_PAD: begin
        cmd.pad_emit = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("controller issued more than one command");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.err_load || cmd.hdr_emit || cmd.pay_emit || cmd.pad_emit) |-> stat.out_free)
    else $error("result issued while output register still holds an unsent byte");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == cfte_pkg::ST_WAIT_END) |-> !stat.pad_zero)
    else $error("waiting for end item with no padding left");
`endif

endmodule
